>>> hdl/cpu_ready_queue_scheduler_top_macros.svh
// Assertion macros used by the ready-queue scheduler controller.
// No dependencies.
`ifndef CPU_READY_QUEUE_SCHEDULER_TOP_MACROS_SVH
`define CPU_READY_QUEUE_SCHEDULER_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
`define CRQS_ASSERT(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define CRQS_ASSERT_NEXT(label, clk, rstn, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) else $error(msg);
`else
`define CRQS_ASSERT(label, clk, rstn, prop, msg)
`define CRQS_ASSERT_NEXT(label, clk, rstn, pre, post, msg)
`endif
`endif

>>> hdl/crqs_pkg.sv
// Package for the ready-queue scheduler: policy codes, item kinds and
// controller/datapath command and status structs. No dependencies.
package crqs_pkg;
  localparam logic [1:0] POL_SJF = 2'd0;
  localparam logic [1:0] POL_SRT = 2'd1;
  localparam logic [1:0] POL_RR  = 2'd2;
  localparam logic [1:0] POL_PRI = 2'd3;

  localparam logic KIND_ARRIVAL = 1'b0;
  localparam logic KIND_TICK    = 1'b1;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_LOAD,     // latch the input item
    CMD_APPEND,   // write the arrival at the tail
    CMD_SCAN,     // compare one entry against the best so far
    CMD_ROT_READ, // rotate: grab the head
    CMD_SHIFT,    // copy entry idx+1 into idx
    CMD_PUT_TAIL, // rotate: put the held head at the tail
    CMD_RUN       // run the chosen entry, form the result
  } crqs_cmd_e;

  typedef struct packed {
    crqs_cmd_e  op;
    logic [1:0] pol;
  } crqs_cmd_t;

  typedef struct packed {
    logic kind;
    logic full;
    logic empty;
    logic keep;     // shortest job first keeps the running task
    logic scan_end; // scan index reached the last entry
    logic shift_end;
    logic finishing;
  } crqs_stat_t;
endpackage

>>> hdl/crqs_datapath.sv
// Datapath of the ready-queue scheduler: the queue memory, the time counter,
// the scan and shift index, and the result register. Uses crqs_pkg.
module crqs_datapath #(
  parameter int QUEUE_DEPTH = 16,
  parameter int TIME_BITS   = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  crqs_pkg::crqs_cmd_t  cmd_i,
  output crqs_pkg::crqs_stat_t stat_i_o,
  input  logic                 kind_i,
  input  logic [7:0]           task_tag_i,
  input  logic [4:0]           service_time_i,
  input  logic [3:0]           task_priority_i,
  output logic                 ran_valid_o,
  output logic [7:0]           ran_tag_o,
  output logic                 finished_o,
  output logic [15:0]          turnaround_o,
  output logic [15:0]          waiting_o,
  output logic                 dropped_o
);
  localparam int IW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [7:0]           tag;
    logic [TIME_BITS-1:0] arr;
    logic [4:0]           svc;
    logic [4:0]           rem;
    logic [3:0]           rank;
  } entry_t;

  entry_t mem_q [QUEUE_DEPTH];

  logic [CW-1:0]        occ_q;
  logic                 cur_v_q;
  logic [IW-1:0]        cur_pos_q;
  logic [TIME_BITS-1:0] now_q;
  logic                 kind_q;
  logic [7:0]           tag_q;
  logic [4:0]           svc_q;
  logic [3:0]           pri_q;
  logic [IW-1:0]        idx_q;
  logic [IW-1:0]        best_q;
  logic [4:0]           best_key_q;
  entry_t               hold_q;
  entry_t               sel;
  entry_t               nxt;
  logic [4:0]           key;
  logic [CW-1:0]        idx_ext;
  logic [TIME_BITS-1:0] done_t;
  logic [TIME_BITS-1:0] turn_t;
  logic [TIME_BITS-1:0] wait_t;

  assign idx_ext = CW'(idx_q);
  assign sel     = mem_q[best_q];
  assign nxt     = mem_q[(idx_q == IW'(QUEUE_DEPTH - 1)) ? idx_q : idx_q + 1'b1];

  always_comb begin
    case (cmd_i.pol)
      crqs_pkg::POL_SJF: key = mem_q[idx_q].svc;
      crqs_pkg::POL_SRT: key = mem_q[idx_q].rem;
      default:           key = {1'b0, mem_q[idx_q].rank};
    endcase
  end

  assign done_t = now_q + 1'b1;
  assign turn_t = done_t - sel.arr;
  assign wait_t = turn_t - TIME_BITS'(sel.svc);

  assign stat_i_o.kind      = kind_q;
  assign stat_i_o.full      = (occ_q >= CW'(QUEUE_DEPTH));
  assign stat_i_o.empty     = (occ_q == '0);
  assign stat_i_o.keep      = cur_v_q && (CW'(cur_pos_q) < occ_q);
  assign stat_i_o.scan_end  = (idx_ext + 1'b1 >= occ_q);
  assign stat_i_o.shift_end = (idx_ext + 2'd2 >= occ_q);
  assign stat_i_o.finishing = (sel.rem <= 5'd1);

  // Queue memory: one write port per cycle.
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      crqs_pkg::CMD_APPEND:
        if (!stat_i_o.full) begin
          mem_q[occ_q[IW-1:0]] <= '{tag: tag_q, arr: now_q, svc: svc_q, rem: svc_q,
                                    rank: pri_q};
        end
      crqs_pkg::CMD_SHIFT:    mem_q[idx_q] <= nxt;
      crqs_pkg::CMD_PUT_TAIL: mem_q[best_q] <= hold_q;
      crqs_pkg::CMD_RUN:
        if (sel.rem > 5'd1) begin
          mem_q[best_q].rem <= sel.rem - 1'b1;
        end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q       <= '0;
      cur_v_q     <= 1'b0;
      cur_pos_q   <= '0;
      now_q       <= '0;
      idx_q       <= '0;
      best_q      <= '0;
      ran_valid_o <= 1'b0;
      finished_o  <= 1'b0;
      dropped_o   <= 1'b0;
    end else begin
      case (cmd_i.op)
        crqs_pkg::CMD_LOAD: begin
          kind_q     <= kind_i;
          tag_q      <= task_tag_i;
          svc_q      <= service_time_i;
          pri_q      <= task_priority_i;
          idx_q      <= '0;
          best_q     <= (cur_v_q && cmd_i.pol == crqs_pkg::POL_SJF) ? cur_pos_q : '0;
          best_key_q <= 5'h1f;
        end
        crqs_pkg::CMD_APPEND: begin
          ran_valid_o  <= 1'b0;
          ran_tag_o    <= '0;
          finished_o   <= 1'b0;
          turnaround_o <= '0;
          waiting_o    <= '0;
          dropped_o    <= stat_i_o.full;
          if (!stat_i_o.full) begin
            occ_q <= occ_q + 1'b1;
          end
        end
        crqs_pkg::CMD_SCAN: begin
          if (idx_q == '0 || key < best_key_q) begin
            best_q     <= idx_q;
            best_key_q <= key;
          end
          idx_q <= idx_q + 1'b1;
        end
        crqs_pkg::CMD_ROT_READ: begin
          hold_q <= mem_q[0];
          idx_q  <= '0;
        end
        crqs_pkg::CMD_SHIFT: begin
          idx_q <= idx_q + 1'b1;
          // A rotation keeps the count; only a removal pass shrinks the queue.
          // Round robin always removes the tail, so its shifts are rotations.
          if (stat_i_o.shift_end && cmd_i.pol != crqs_pkg::POL_RR) begin
            occ_q <= occ_q - 1'b1;
          end
        end
        crqs_pkg::CMD_PUT_TAIL: ;
        crqs_pkg::CMD_RUN: begin
          dropped_o <= 1'b0;
          now_q     <= now_q + 1'b1;
          if (stat_i_o.empty) begin
            ran_valid_o  <= 1'b0;
            ran_tag_o    <= '0;
            finished_o   <= 1'b0;
            turnaround_o <= '0;
            waiting_o    <= '0;
          end else begin
            ran_valid_o <= 1'b1;
            ran_tag_o   <= sel.tag;
            finished_o  <= stat_i_o.finishing;
            if (stat_i_o.finishing) begin
              turnaround_o <= 16'(turn_t);
              waiting_o    <= 16'(wait_t);
              cur_v_q      <= 1'b0;
              cur_pos_q    <= '0;
              idx_q        <= best_q;
              // A removed last entry needs no shift pass.
              if (CW'(best_q) + 1'b1 >= occ_q) begin
                occ_q <= occ_q - 1'b1;
              end
            end else begin
              turnaround_o <= '0;
              waiting_o    <= '0;
              cur_v_q      <= 1'b1;
              cur_pos_q    <= best_q;
            end
          end
        end
        default: ;
      endcase
      if (cmd_i.op == crqs_pkg::CMD_ROT_READ) begin
        best_q <= IW'(occ_q - 1'b1);
      end
    end
  end
endmodule

>>> hdl/crqs_ctrl.sv
// Controller of the ready-queue scheduler: sequences load, append, scan, rotate,
// run and removal steps. Uses crqs_pkg and the assertion macro header.
`include "cpu_ready_queue_scheduler_top_macros.svh"
module crqs_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  logic [1:0]           policy_i,
  input  crqs_pkg::crqs_stat_t stat_i,
  output crqs_pkg::crqs_cmd_t  cmd_o
);
  typedef enum logic [2:0] {
    S_IDLE, S_DISPATCH, S_SCAN, S_ROT, S_PUT, S_RUN, S_SHIFT, S_OUT
  } state_e;

  state_e state_q;

  assign in_ready_o   = (state_q == S_IDLE);
  assign cmd_o.pol    = policy_i;

  always_comb begin
    unique case (state_q)
      S_IDLE:     cmd_o.op = in_valid_i ? crqs_pkg::CMD_LOAD : crqs_pkg::CMD_NONE;
      S_DISPATCH: cmd_o.op = (stat_i.kind == crqs_pkg::KIND_ARRIVAL) ? crqs_pkg::CMD_APPEND :
                             (stat_i.empty || (policy_i == crqs_pkg::POL_SJF && stat_i.keep))
                             ? crqs_pkg::CMD_RUN :
                             (policy_i == crqs_pkg::POL_RR) ? crqs_pkg::CMD_ROT_READ :
                             crqs_pkg::CMD_SCAN;
      S_SCAN:     cmd_o.op = crqs_pkg::CMD_SCAN;
      S_ROT:      cmd_o.op = stat_i.scan_end ? crqs_pkg::CMD_NONE : crqs_pkg::CMD_SHIFT;
      S_PUT:      cmd_o.op = crqs_pkg::CMD_PUT_TAIL;
      S_RUN:      cmd_o.op = crqs_pkg::CMD_RUN;
      S_SHIFT:    cmd_o.op = stat_i.scan_end ? crqs_pkg::CMD_NONE : crqs_pkg::CMD_SHIFT;
      S_OUT:      cmd_o.op = crqs_pkg::CMD_NONE;
      default:    cmd_o.op = crqs_pkg::CMD_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_o <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE:
          if (in_valid_i) begin
            state_q <= S_DISPATCH;
          end
        S_DISPATCH:
          unique case (cmd_o.op)
            crqs_pkg::CMD_APPEND: begin
              state_q     <= S_OUT;
              out_valid_o <= 1'b1;
            end
            crqs_pkg::CMD_RUN:      state_q <= stat_i.finishing && !stat_i.empty ? S_SHIFT : S_OUT;
            crqs_pkg::CMD_ROT_READ: state_q <= S_ROT;
            default:                state_q <= stat_i.scan_end ? S_RUN : S_SCAN;
          endcase
        S_SCAN:
          if (stat_i.scan_end) begin
            state_q <= S_RUN;
          end
        S_ROT:
          if (stat_i.shift_end) begin
            state_q <= S_PUT;
          end
        S_PUT:   state_q <= S_RUN;
        S_RUN:   state_q <= stat_i.finishing ? S_SHIFT : S_OUT;
        S_SHIFT:
          if (stat_i.shift_end) begin
            state_q <= S_OUT;
          end
        S_OUT: begin
          out_valid_o <= 1'b1;
          if (out_valid_o && out_ready_i) begin
            out_valid_o <= 1'b0;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  `CRQS_ASSERT(a_out_only_in_out, clk_i, rst_ni, !out_valid_o || state_q == S_OUT, "result shown outside output state")
  `CRQS_ASSERT(a_ready_not_busy, clk_i, rst_ni, !(in_ready_o && out_valid_o), "input taken while result waits")
  `CRQS_ASSERT_NEXT(a_accept_dispatch, clk_i, rst_ni, in_valid_i && in_ready_o, state_q == S_DISPATCH, "accepted item not dispatched")
endmodule

>>> hdl/cpu_ready_queue_scheduler_top.sv
// Ready-queue CPU scheduler: four policies over a queue of QUEUE_DEPTH tasks.
// An arrival is appended at the tail, or dropped if the queue is full. A tick,
// unless the queue is empty or shortest job first keeps the running task, scans or
// rotates the queue one entry a cycle, runs the chosen task and, when it finishes,
// shifts it out of the queue memory. Only one item is in flight at a time.
// Reset (rst_ni low, asynchronous) empties the queue, clears time and sets
// the policy to shortest job first; queue entries themselves are not cleared.
module cpu_ready_queue_scheduler_top #(
  parameter int QUEUE_DEPTH = 16,
  parameter int TIME_BITS   = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        kind_i,
  input  logic [7:0]  task_tag_i,
  input  logic [4:0]  service_time_i,
  input  logic [3:0]  task_priority_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        ran_valid_o,
  output logic [7:0]  ran_tag_o,
  output logic        finished_o,
  output logic [15:0] turnaround_o,
  output logic [15:0] waiting_o,
  output logic        dropped_o
);
  // The policy register is written directly; write it only while idle (not enforced).
  logic [1:0] policy_q;
  crqs_pkg::crqs_cmd_t  cmd;
  crqs_pkg::crqs_stat_t stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q <= crqs_pkg::POL_SJF;
    end else if (cfg_we_i) begin
      policy_q <= cfg_wdata_i;
    end
  end

  // The controller steps through the transfer; the datapath holds the queue.
  crqs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .policy_i    (policy_q),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  crqs_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TIME_BITS   (TIME_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_i_o        (stat),
    .kind_i          (kind_i),
    .task_tag_i      (task_tag_i),
    .service_time_i  (service_time_i),
    .task_priority_i (task_priority_i),
    .ran_valid_o     (ran_valid_o),
    .ran_tag_o       (ran_tag_o),
    .finished_o      (finished_o),
    .turnaround_o    (turnaround_o),
    .waiting_o       (waiting_o),
    .dropped_o       (dropped_o)
  );
endmodule
